[hdl/eas_pkg.sv]
`timescale 1ns / 1ps
// eas_pkg: shared types and constants of the encoder angle speed estimator
// no dependencies; used by encoder_angle_speed_estimator

package eas_pkg;

  // thousandths of rpm per turn per microsecond: 60e6 us/min * 1000
  localparam logic [35:0] SPEED_SCALE   = 36'd60000000000;
  localparam logic [18:0] MDEG_PER_TURN = 19'd360000;

  // scaled dividend width: mag * SPEED_SCALE / 2^ANGLE_BITS stays below 2^35
  localparam int unsigned QW    = 35;
  localparam int unsigned CNT_W = 6;

  localparam logic [31:0] SPEED_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

[hdl/encoder_angle_speed_estimator.sv]
`timescale 1ns / 1ps
// encoder_angle_speed_estimator: speed and angle from absolute angle samples
// depends on eas_pkg (types and constants)
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | sensor_angle, sample_time_us, read_ok
//  out      | out_valid / out_stall| ok, angle_out, angle_millideg,
//           |                      | speed_milli_rpm
//  cfg      | cfg_we               | cfg_wdata (enable)
//
// one word at a time; a word that needs a speed quotient goes through a
// bit-serial shift-add multiply of the angle change by the speed scale
// (one bit per cycle), then a restoring divide by the elapsed time
// (one quotient bit per cycle)
// refused words, first samples and zero elapsed time skip the multiply and divide
// the result sits in an output register, so the next word is taken while
// a finished result still waits on out_stall
// rst is synchronous and clears enable and all sample history

module encoder_angle_speed_estimator #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        sensor_angle,
  input  logic [63:0]        sample_time_us,
  input  logic               read_ok,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [11:0]        angle_out,
  output logic [18:0]        angle_millideg,
  output logic signed [31:0] speed_milli_rpm
);

  localparam int unsigned DW    = ANGLE_BITS + 2;  // signed angle difference
  localparam int unsigned PW    = ANGLE_BITS + 36; // product accumulator
  localparam int unsigned PRODW = ANGLE_BITS + 19; // millidegree product
  localparam logic signed [DW-1:0] HALF_TURN = DW'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [DW-1:0] FULL_TURN = DW'(2 ** ANGLE_BITS);

  // control and history
  eas_pkg::state_t              state;
  logic                         enable;
  logic                         have_sample;
  logic [ANGLE_BITS-1:0]        prev_angle;
  logic [31:0]                  prev_time;   // only the low 32 bits matter
  logic [31:0]                  last_speed;
  logic [eas_pkg::CNT_W-1:0]    cnt;

  // datapath
  logic [ANGLE_BITS-1:0]        mag;         // multiplier bits, msb first
  logic                         neg;
  logic [PW-1:0]                acc;
  logic [PW-1:0]                acc_next;
  logic [31:0]                  den;
  logic [31:0]                  rem;
  logic [31:0]                  rem_next;
  logic [eas_pkg::QW-1:0]       dq;          // dividend out, quotient in
  logic [eas_pkg::QW-1:0]       dq_next;
  logic [32:0]                  trial;
  logic [31:0]                  speed_sat;

  // pending result
  logic                         res_ok;
  logic [11:0]                  res_angle;
  logic [18:0]                  res_mdeg;
  logic [31:0]                  res_speed;

  // sample decode
  logic [ANGLE_BITS-1:0]        angle;
  logic signed [DW-1:0]         diff;
  logic signed [DW-1:0]         wrapped;
  logic signed [DW-1:0]         mag_full;
  logic [31:0]                  elapsed;
  logic [PRODW-1:0]             mdeg_prod;
  logic                         accept;
  logic                         out_free;

  assign in_stall = (state != eas_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign angle     = ANGLE_BITS'(sensor_angle);
  assign elapsed   = sample_time_us[31:0] - prev_time;
  assign mdeg_prod = PRODW'(angle) * PRODW'(eas_pkg::MDEG_PER_TURN);

  // wrap the change into one half turn either way; exactly a half turn
  // keeps its sign
  always_comb begin
    diff = $signed({2'b00, angle}) - $signed({2'b00, prev_angle});
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
    mag_full = wrapped[DW-1] ? -wrapped : wrapped;
  end

  // shift-add multiply step
  assign acc_next = {acc[PW-2:0], 1'b0}
                  + (mag[ANGLE_BITS-1] ? PW'(eas_pkg::SPEED_SCALE) : PW'(0));

  // restoring divide step
  always_comb begin
    trial = {rem, dq[eas_pkg::QW-1]};
    if (trial >= {1'b0, den}) begin
      rem_next = 32'(trial - {1'b0, den});
      dq_next  = {dq[eas_pkg::QW-2:0], 1'b1};
    end else begin
      rem_next = trial[31:0];
      dq_next  = {dq[eas_pkg::QW-2:0], 1'b0};
    end
  end

  // sign and saturation of the finished quotient
  always_comb begin
    if (neg) begin
      if (dq_next >= eas_pkg::QW'(33'h0_8000_0000)) begin
        speed_sat = eas_pkg::SPEED_MIN;
      end else begin
        speed_sat = -dq_next[31:0];
      end
    end else begin
      if (dq_next > eas_pkg::QW'(eas_pkg::SPEED_MAX)) begin
        speed_sat = eas_pkg::SPEED_MAX;
      end else begin
        speed_sat = dq_next[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= eas_pkg::ST_IDLE;
      enable      <= 1'b0;
      have_sample <= 1'b0;
      prev_angle  <= '0;
      prev_time   <= '0;
      last_speed  <= '0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      // output register loads from the done state, empties when taken
      if (state == eas_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        eas_pkg::ST_IDLE: begin
          if (accept) begin
            if (!enable || !read_ok) begin
              // refused word: zero fields, history untouched
              res_ok    <= 1'b0;
              res_angle <= '0;
              res_mdeg  <= '0;
              res_speed <= '0;
              state     <= eas_pkg::ST_DONE;
            end else begin
              prev_angle  <= angle;
              prev_time   <= sample_time_us[31:0];
              have_sample <= 1'b1;
              res_ok      <= 1'b1;
              res_angle   <= 12'(angle);
              res_mdeg    <= mdeg_prod[ANGLE_BITS+18:ANGLE_BITS];
              if (!have_sample) begin
                last_speed <= '0;
                res_speed  <= '0;
                state      <= eas_pkg::ST_DONE;
              end else if (elapsed == 32'd0) begin
                res_speed <= last_speed;
                state     <= eas_pkg::ST_DONE;
              end else begin
                mag   <= mag_full[ANGLE_BITS-1:0];
                neg   <= wrapped[DW-1];
                den   <= elapsed;
                acc   <= '0;
                cnt   <= eas_pkg::CNT_W'(ANGLE_BITS - 1);
                state <= eas_pkg::ST_MUL;
              end
            end
          end
        end

        eas_pkg::ST_MUL: begin
          acc <= acc_next;
          mag <= {mag[ANGLE_BITS-2:0], 1'b0};
          if (cnt == '0) begin
            // divide out the 2^ANGLE_BITS counts per turn
            dq    <= acc_next[ANGLE_BITS+eas_pkg::QW-1:ANGLE_BITS];
            rem   <= '0;
            cnt   <= eas_pkg::CNT_W'(eas_pkg::QW - 1);
            state <= eas_pkg::ST_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        eas_pkg::ST_DIV: begin
          rem <= rem_next;
          dq  <= dq_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            last_speed <= speed_sat;
            res_speed  <= speed_sat;
            state      <= eas_pkg::ST_DONE;
          end
        end

        eas_pkg::ST_DONE: begin
          if (out_free) begin
            ok              <= res_ok;
            angle_out       <= res_angle;
            angle_millideg  <= res_mdeg;
            speed_milli_rpm <= $signed(res_speed);
            state           <= eas_pkg::ST_IDLE;
          end
        end

        default: begin
          state <= eas_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
